// ===== hdl/i2ctmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2ctmp_pkg;

  // Bus protocol phase of the target
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_RX   = 2'd2,
    PH_TX   = 2'd3
  } phase_t;

  // Positions in the byte frame: eight data bits, then the ACK bit
  localparam logic [3:0] BIT_ZERO = 4'd0;
  localparam logic [3:0] BIT_FIRST = 4'd1;
  localparam logic [3:0] BIT_LAST_DATA = 4'd7;
  localparam logic [3:0] BIT_ACK = 4'd8;
  localparam logic [3:0] BIT_ACK_DONE = 4'd9;

  localparam logic [6:0] OWN_ADDR_RESET = 7'h02;

  // One line sample per beat
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] tx_byte;
  } in_item_t;

  // One result per beat
  typedef struct packed {
    logic       sda_pull_low;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_taken;
    logic       addressed;
    logic       message_end;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/i2c_target_message_port_core.sv =====
// Channel | Ports                               | Direction | Beat
// --------+-------------------------------------+-----------+--------------------------
// input   | in_valid, in_stall, in_item         | in        | one SCL/SDA sample
// result  | out_valid, out_stall, out_item      | out       | one result per sample
// config  | cfg_valid, cfg_ready, cfg_own_address | in      | own 7-bit bus address
//
// Each accepted sample is processed in the cycle it is taken; its result is
// registered (in the skid register first while the output register is held) and
// shows on out_valid. One sample per cycle while in_stall is low. A two-entry
// output buffer (output register plus skid register) parts the channels: in_stall
// rises only when both entries hold results. rst_n is synchronous, active low; it
// idles the bus state and sets the own address to 2. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module i2c_target_message_port_core
  import i2ctmp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [6:0] cfg_own_address
);

  logic       cfg_write;
  logic [6:0] own_address_r;
  logic       scl_prev_r, scl_prev_nxt;
  logic       sda_prev_r, sda_prev_nxt;
  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       read_mode_r, read_mode_nxt;
  logic       drive_low_r, drive_low_nxt;
  logic       zero_seen_r, zero_seen_nxt;

  logic       rx_valid_c, tx_taken_c, mend_c;
  logic [7:0] rx_byte_c;
  logic [7:0] shift_in;
  out_item_t  result_c;

  logic       accept, pop;
  logic       skid_valid_r;
  out_item_t  skid_item_r;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid & cfg_ready;
  assign accept     = in_valid & ~in_stall;
  assign pop        = out_valid & ~out_stall;
  assign in_stall   = skid_valid_r;
  assign shift_in   = {shift_r[6:0], in_item.sda};

  // Next bus state for one sample
  always_comb begin
    logic rise, fall, hold_high, addressed_now;
    rise          = ~scl_prev_r & in_item.scl;
    fall          = scl_prev_r & ~in_item.scl;
    hold_high     = scl_prev_r & in_item.scl;
    addressed_now = (phase_r == PH_RX) || (phase_r == PH_TX) ||
                    ((phase_r == PH_ADDR) && (bit_cnt_r >= BIT_ACK));

    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    read_mode_nxt = read_mode_r;
    drive_low_nxt = drive_low_r;
    zero_seen_nxt = zero_seen_r;
    scl_prev_nxt  = in_item.scl;
    sda_prev_nxt  = in_item.sda;
    rx_valid_c    = 1'b0;
    rx_byte_c     = 8'h00;
    tx_taken_c    = 1'b0;
    mend_c        = 1'b0;

    if (hold_high && sda_prev_r && !in_item.sda) begin
      // START: restart address reception
      phase_nxt     = PH_ADDR;
      bit_cnt_nxt   = BIT_ZERO;
      drive_low_nxt = 1'b0;
      zero_seen_nxt = 1'b0;
      shift_nxt     = 8'h00;
      read_mode_nxt = 1'b0;
    end else if (hold_high && !sda_prev_r && in_item.sda) begin
      // STOP: end any message and release the line
      mend_c        = addressed_now;
      phase_nxt     = PH_IDLE;
      bit_cnt_nxt   = BIT_ZERO;
      drive_low_nxt = 1'b0;
      zero_seen_nxt = 1'b0;
    end else if (rise) begin
      if (phase_r == PH_ADDR || phase_r == PH_RX) begin
        if (bit_cnt_r < BIT_ACK) begin
          // Shift in one bit; check the byte once complete
          shift_nxt   = shift_in;
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          if (bit_cnt_r == BIT_LAST_DATA) begin
            if (phase_r == PH_ADDR) begin
              if (shift_in[7:1] == own_address_r) begin
                read_mode_nxt = shift_in[0];
              end else begin
                phase_nxt     = PH_IDLE;
                bit_cnt_nxt   = BIT_ZERO;
                drive_low_nxt = 1'b0;
                zero_seen_nxt = 1'b0;
              end
            end else begin
              rx_valid_c = 1'b1;
              rx_byte_c  = shift_in;
              if (shift_in == 8'h00) begin
                zero_seen_nxt = 1'b1;
                mend_c        = 1'b1;
              end
            end
          end
        end
      end else if (phase_r == PH_TX) begin
        if (bit_cnt_r < BIT_ACK) begin
          bit_cnt_nxt = bit_cnt_r + 4'd1;
        end else if (bit_cnt_r == BIT_ACK) begin
          // Sample master ACK; NACK or sent zero byte ends the message
          if (in_item.sda || zero_seen_r) begin
            mend_c        = 1'b1;
            phase_nxt     = PH_IDLE;
            bit_cnt_nxt   = BIT_ZERO;
            drive_low_nxt = 1'b0;
            zero_seen_nxt = 1'b0;
          end else begin
            bit_cnt_nxt = BIT_ACK_DONE;
          end
        end
      end
    end else if (fall) begin
      if (phase_r == PH_ADDR || phase_r == PH_RX) begin
        if (bit_cnt_r == BIT_ACK) begin
          // Drive ACK during the ACK bit after the byte
          drive_low_nxt = 1'b1;
          bit_cnt_nxt   = BIT_ACK_DONE;
        end else if (bit_cnt_r == BIT_ACK_DONE) begin
          drive_low_nxt = 1'b0;
          bit_cnt_nxt   = BIT_ZERO;
          shift_nxt     = 8'h00;
          if (phase_r == PH_ADDR) begin
            if (read_mode_r) begin
              phase_nxt     = PH_TX;
              shift_nxt     = in_item.tx_byte;
              zero_seen_nxt = (in_item.tx_byte == 8'h00);
              drive_low_nxt = ~in_item.tx_byte[7];
              tx_taken_c    = 1'b1;
            end else begin
              phase_nxt = PH_RX;
            end
          end else if (zero_seen_r) begin
            phase_nxt     = PH_IDLE;
            zero_seen_nxt = 1'b0;
          end
        end
      end else if (phase_r == PH_TX) begin
        if (bit_cnt_r >= BIT_FIRST && bit_cnt_r <= BIT_LAST_DATA) begin
          // Advance to the next bit, MSB first
          shift_nxt     = {shift_r[6:0], 1'b0};
          drive_low_nxt = ~shift_r[6];
        end else if (bit_cnt_r == BIT_ACK) begin
          drive_low_nxt = 1'b0;
        end else if (bit_cnt_r == BIT_ACK_DONE) begin
          // Latch the next byte to send
          shift_nxt     = in_item.tx_byte;
          zero_seen_nxt = (in_item.tx_byte == 8'h00);
          drive_low_nxt = ~in_item.tx_byte[7];
          bit_cnt_nxt   = BIT_ZERO;
          tx_taken_c    = 1'b1;
        end
      end
    end
  end

  // Assemble the result from the next state
  always_comb begin
    result_c.sda_pull_low = drive_low_nxt;
    result_c.rx_valid     = rx_valid_c;
    result_c.rx_byte      = rx_byte_c;
    result_c.tx_taken     = tx_taken_c;
    result_c.addressed    = (phase_nxt == PH_RX) || (phase_nxt == PH_TX) ||
                            ((phase_nxt == PH_ADDR) && (bit_cnt_nxt >= BIT_ACK));
    result_c.message_end  = mend_c;
  end

  // Bus state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= OWN_ADDR_RESET;
      scl_prev_r    <= 1'b1;
      sda_prev_r    <= 1'b1;
      phase_r       <= PH_IDLE;
      bit_cnt_r     <= BIT_ZERO;
      shift_r       <= 8'h00;
      read_mode_r   <= 1'b0;
      drive_low_r   <= 1'b0;
      zero_seen_r   <= 1'b0;
    end else begin
      if (cfg_write) begin
        own_address_r <= cfg_own_address;
      end
      if (accept) begin
        scl_prev_r  <= scl_prev_nxt;
        sda_prev_r  <= sda_prev_nxt;
        phase_r     <= phase_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        shift_r     <= shift_nxt;
        read_mode_r <= read_mode_nxt;
        drive_low_r <= drive_low_nxt;
        zero_seen_r <= zero_seen_nxt;
      end
    end
  end

  // Output register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid    <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid_r) begin
          out_valid    <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid <= accept;
        end
      end else if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid_r) begin
        out_item <= skid_item_r;
      end else if (accept) begin
        out_item <= result_c;
      end
    end else if (accept) begin
      skid_item_r <= result_c;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2ctmp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2ctmp_checker
  import i2ctmp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // A received byte only while addressed
  a_rx_addressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.rx_valid |-> out_item.addressed)
    else $error("rx byte outside an addressed transfer");

  // A zero data byte ends the message
  a_zero_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.rx_valid && out_item.rx_byte == 8'h00
      |-> out_item.message_end)
    else $error("zero byte without message end");

  // Bytes are latched for sending only in an addressed read
  a_tx_addressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.tx_taken |-> out_item.addressed && !out_item.rx_valid)
    else $error("tx byte taken outside an addressed read");

endmodule

bind i2c_target_message_port_core i2ctmp_checker u_i2ctmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

// ===== dv/i2c_target_message_port_core_tb.sv =====
`timescale 1ns / 1ps

module i2c_target_message_port_core_tb;
  import i2ctmp_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int SAMPLES_PER_STEP = 230;
  localparam int HOLDOFF_AT = 400;
  localparam int HOLDOFF_LEN = 150;
  localparam int STUCK_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;

  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_own_address;

  // Line samples waiting to go out, and the port outputs they should produce
  in_item_t line_samples[$];
  out_item_t target_outputs[$];

  // Target state as the bus protocol sees it
  logic [6:0] own_addr;
  logic line_scl_q;
  logic line_sda_q;
  phase_t bus_phase;
  logic [3:0] frame_pos;
  logic [7:0] shifter;
  logic is_read;
  logic pull_low;
  logic zero_byte;

  // Master side line levels while building samples
  logic bus_scl;
  logic bus_sda;
  int samples_built = 0;

  bit in_fire = 1'b0;
  bit quiet = 1'b0;
  bit holdoff_done = 1'b0;
  int in_gap_pct = 0;
  int out_gap_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int holdoff_left = 0;
  int outputs_checked = 0;
  int mismatches = 0;
  int stuck_cycles = 0;

  i2c_target_message_port_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_own_address(cfg_own_address)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bus target prediction
  // ---------------------------------------------------------------------------

  function automatic logic target_addressed();
    return (bus_phase == PH_RX) || (bus_phase == PH_TX) ||
           ((bus_phase == PH_ADDR) && (frame_pos >= BIT_ACK));
  endfunction

  function automatic void release_bus();
    bus_phase = PH_IDLE;
    frame_pos = BIT_ZERO;
    pull_low = 1'b0;
    zero_byte = 1'b0;
  endfunction

  // Latch the next byte to send and put its MSB on the line
  function automatic void latch_tx(logic [7:0] b);
    shifter = b;
    zero_byte = (b == 8'h00);
    pull_low = ~b[7];
    frame_pos = BIT_ZERO;
  endfunction

  function automatic out_item_t target_step(in_item_t s);
    out_item_t r;
    logic rise;
    logic fall;
    logic hold;
    r = '0;
    rise = !line_scl_q && s.scl;
    fall = line_scl_q && !s.scl;
    hold = line_scl_q && s.scl;

    if (hold && line_sda_q && !s.sda) begin
      // START, repeated or not: restart address reception
      release_bus();
      bus_phase = PH_ADDR;
      shifter = 8'h00;
      is_read = 1'b0;
    end else if (hold && !line_sda_q && s.sda) begin
      // STOP ends the message only if we were addressed
      if (target_addressed()) r.message_end = 1'b1;
      release_bus();
    end else if (rise) begin
      if (bus_phase == PH_ADDR || bus_phase == PH_RX) begin
        if (frame_pos < BIT_ACK) begin
          shifter = {shifter[6:0], s.sda};
          frame_pos = frame_pos + 4'd1;
          if (frame_pos == BIT_ACK) begin
            if (bus_phase == PH_ADDR) begin
              if (shifter[7:1] == own_addr) is_read = shifter[0];
              else release_bus();
            end else begin
              r.rx_valid = 1'b1;
              r.rx_byte = shifter;
              if (shifter == 8'h00) begin
                zero_byte = 1'b1;
                r.message_end = 1'b1;
              end
            end
          end
        end
      end else if (bus_phase == PH_TX) begin
        if (frame_pos < BIT_ACK) begin
          frame_pos = frame_pos + 4'd1;
        end else if (frame_pos == BIT_ACK) begin
          // master NACK, or ACK of a zero byte, ends the read
          if (s.sda || zero_byte) begin
            r.message_end = 1'b1;
            release_bus();
          end else begin
            frame_pos = BIT_ACK_DONE;
          end
        end
      end
    end else if (fall) begin
      if (bus_phase == PH_ADDR || bus_phase == PH_RX) begin
        if (frame_pos == BIT_ACK) begin
          pull_low = 1'b1;
          frame_pos = BIT_ACK_DONE;
        end else if (frame_pos == BIT_ACK_DONE) begin
          pull_low = 1'b0;
          frame_pos = BIT_ZERO;
          shifter = 8'h00;
          if (bus_phase == PH_ADDR) begin
            if (is_read) begin
              bus_phase = PH_TX;
              latch_tx(s.tx_byte);
              r.tx_taken = 1'b1;
            end else begin
              bus_phase = PH_RX;
            end
          end else if (zero_byte) begin
            release_bus();
          end
        end
      end else if (bus_phase == PH_TX) begin
        if (frame_pos >= BIT_FIRST && frame_pos <= BIT_LAST_DATA) begin
          shifter = {shifter[6:0], 1'b0};
          pull_low = ~shifter[7];
        end else if (frame_pos == BIT_ACK) begin
          pull_low = 1'b0;
        end else if (frame_pos == BIT_ACK_DONE) begin
          latch_tx(s.tx_byte);
          r.tx_taken = 1'b1;
        end
      end
    end

    line_scl_q = s.scl;
    line_sda_q = s.sda;
    r.sda_pull_low = pull_low;
    r.addressed = target_addressed();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus master sequences, built as line samples
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_tx_byte();
    if ($urandom_range(0, 7) == 0) return 8'h00;
    if ($urandom_range(0, 7) == 0) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_data_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic put_tx(input logic c, input logic d, input logic [7:0] t);
    in_item_t it;
    it.scl = c;
    it.sda = d;
    it.tx_byte = t;
    line_samples.push_back(it);
    bus_scl = c;
    bus_sda = d;
    samples_built++;
  endtask

  task automatic put(input logic c, input logic d);
    put_tx(c, d, pick_tx_byte());
  endtask

  // Change data only with SCL low; sometimes fold the fall into the data change
  task automatic send_bit(input logic b);
    if (bus_scl) begin
      if ($urandom_range(0, 3) == 0) begin
        put(1'b0, b);
      end else begin
        put(1'b0, bus_sda);
        put(1'b0, b);
      end
    end else begin
      put(1'b0, b);
    end
    put(1'b1, b);
    if ($urandom_range(0, 4) == 0) put(1'b1, b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    for (int k = 7; k >= 0; k--) send_bit(b[k]);
  endtask

  task automatic send_start();
    if (!(bus_scl && bus_sda)) begin
      if (bus_scl) put(1'b0, bus_sda);
      put(1'b0, 1'b1);
      put(1'b1, 1'b1);
    end
    put(1'b1, 1'b0);
  endtask

  task automatic send_stop();
    if (bus_scl) put(1'b0, bus_sda);
    put(1'b0, 1'b0);
    put(1'b1, 1'b0);
    put(1'b1, 1'b1);
  endtask

  // One message: address, then data written or read; sometimes cut short
  task automatic run_message(input logic [6:0] target);
    logic [6:0] a;
    logic rd;
    logic cut;
    int nbytes;
    int nbits;
    a = ($urandom_range(0, 3) != 0) ? target : 7'($urandom_range(0, 127));
    rd = 1'($urandom_range(0, 1));
    cut = 1'b0;
    nbytes = $urandom_range(1, 3);

    // line noise between messages
    if ($urandom_range(0, 9) == 0) begin
      nbits = $urandom_range(2, 6);
      for (int k = 0; k < nbits; k++) put(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end

    send_start();
    send_byte({a, rd});
    send_bit(1'b1);
    for (int i = 0; i < nbytes && !cut; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        // broken frame: a few bits, then STOP or START
        nbits = $urandom_range(1, 7);
        for (int k = 0; k < nbits; k++) send_bit(1'($urandom_range(0, 1)));
        cut = 1'b1;
      end else if (rd) begin
        send_byte(8'hFF);
        if (i == nbytes - 1) send_bit($urandom_range(0, 3) != 0);
        else send_bit(1'b0);
      end else begin
        send_byte(pick_data_byte());
        send_bit(1'b1);
      end
    end
    // without a STOP the next message begins with a repeated START
    if ($urandom_range(0, 3) != 0) send_stop();
  endtask

  task automatic write_own_address(input logic [6:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_own_address <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    own_addr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the oldest sample, hold it until taken
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
        in_gap = $urandom_range(1, 12) - 1;
        in_valid <= 1'b0;
      end else if (line_samples.size() > 0) begin
        in_valid <= 1'b1;
        in_item <= line_samples[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      target_outputs.push_back(target_step(in_item));
      void'(line_samples.pop_front());
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall bursts, one long hold-off, and the check
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else if (!holdoff_done && outputs_checked >= HOLDOFF_AT) begin
      // hold off long enough for the block to fill and stall its input
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN - 1;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < out_gap_pct) begin
      out_gap = $urandom_range(1, 12) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      outputs_checked++;
      if (target_outputs.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %p", $time, out_item);
        mismatches++;
      end else begin
        want = target_outputs.pop_front();
        check_field("sda_pull_low", want.sda_pull_low, out_item.sda_pull_low);
        check_field("rx_valid", want.rx_valid, out_item.rx_valid);
        check_field("rx_byte", want.rx_byte, out_item.rx_byte);
        check_field("tx_taken", want.tx_taken, out_item.tx_taken);
        check_field("addressed", want.addressed, out_item.addressed);
        check_field("message_end", want.message_end, out_item.message_end);
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("** i2c_target_message_port_core: FAILED **");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    logic [6:0] step_addr[5];
    int step_base;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_own_address = OWN_ADDR_RESET;

    own_addr = OWN_ADDR_RESET;
    line_scl_q = 1'b1;
    line_sda_q = 1'b1;
    bus_phase = PH_IDLE;
    frame_pos = BIT_ZERO;
    shifter = 8'h00;
    is_read = 1'b0;
    pull_low = 1'b0;
    zero_byte = 1'b0;
    bus_scl = 1'b1;
    bus_sda = 1'b1;

    step_addr[0] = OWN_ADDR_RESET;
    step_addr[1] = 7'h7F;
    step_addr[2] = 7'h00;
    step_addr[3] = 7'($urandom_range(0, 127));
    step_addr[4] = 7'($urandom_range(0, 127));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Idle line with tx_byte extremes; clock edges while idle do nothing
    put_tx(1'b1, 1'b1, 8'hFF);
    put_tx(1'b0, 1'b1, 8'h00);
    put_tx(1'b1, 1'b1, 8'h00);
    put_tx(1'b0, 1'b1, 8'hFF);
    // STOP while idle
    put(1'b0, 1'b0);
    put(1'b1, 1'b0);
    put(1'b1, 1'b1);
    // START, one address bit, then START again during the address byte
    put(1'b1, 1'b0);
    put(1'b0, 1'b0);
    put(1'b0, 1'b1);
    put(1'b1, 1'b1);
    put(1'b1, 1'b0);
    // SCL falls and SDA rises together: a clock edge only
    put(1'b0, 1'b1);
    put(1'b1, 1'b1);
    put(1'b1, 1'b0);
    // STOP during the address byte: no message end
    put(1'b0, 1'b0);
    put(1'b1, 1'b0);
    put(1'b1, 1'b1);

    for (int st = 0; st < 5; st++) begin
      if (st > 0) begin
        while (line_samples.size() != 0 || target_outputs.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        write_own_address(step_addr[st]);
      end
      in_gap_pct = (st == 2) ? 0 : $urandom_range(0, 2) * 12;
      out_gap_pct = (st == 2) ? 0 : $urandom_range(0, 2) * 12;
      quiet = (st == 4);
      step_base = samples_built;
      while (samples_built - step_base < SAMPLES_PER_STEP) run_message(step_addr[st]);
      send_stop();
      put(1'b1, 1'b1);
    end

    while (line_samples.size() != 0 || target_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** i2c_target_message_port_core: PASSED **");
    end else begin
      $display("** i2c_target_message_port_core: FAILED **");
    end
    $finish;
  end

endmodule
